FILE: design/assert_macros.svh
// assertion macros used by the tokenizer top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define QWT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tokenizer assertion failed");

// condition at one edge implies another condition at the next edge
`define QWT_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("tokenizer assertion failed");

`endif

FILE: design/qwt_pkg.sv
// package for the quoted word tokenizer: item types, character codes, kinds
// no dependencies
`timescale 1ns / 1ps

package qwt_pkg;

    localparam int unsigned BufSizeW = 16;
    localparam logic [BufSizeW-1:0] BUF_SIZE_RESET = 16'd256;

    // item kinds
    localparam logic [2:0] KIND_UNQUOTED = 3'd0;
    localparam logic [2:0] KIND_QUOTED   = 3'd1;
    localparam logic [2:0] KIND_NOTHING  = 3'd2;
    localparam logic [2:0] KIND_EQUAL    = 3'd3;
    localparam logic [2:0] KIND_ERROR    = 3'd4;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_EQUAL = 8'h3d;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_UP_N  = 8'h4e;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_LO_N  = 8'h6e;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic                write_enable;
        logic [BufSizeW-1:0] write_index;
        logic [7:0]          write_byte;
        logic                item_done;
        logic [2:0]          item_kind;
        logic                consumed;
    } t_out_item;

endpackage

FILE: design/qwt_core.sv
// tokenizer core: phase and write position state, per-item step logic
// depends on qwt_pkg
`timescale 1ns / 1ps

module qwt_core
    import qwt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  t_in_item            i_item,
    input  logic [BufSizeW-1:0] i_buffer_size,
    output t_out_item           o_result
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_UNQ,
        PH_QUO,
        PH_ESC
    } t_phase;

    t_phase              r_phase;
    t_phase              n_phase;
    logic [BufSizeW-1:0] r_pos;
    logic [BufSizeW-1:0] n_pos;

    logic                eof;
    logic [7:0]          c;
    logic                line_end;
    logic                do_store;
    logic [BufSizeW-1:0] store_pos;
    logic [7:0]          store_byte;
    logic [2:0]          full_kind;
    logic [BufSizeW-1:0] back_idx;

    function automatic t_out_item f_finish(logic [BufSizeW-1:0] idx, logic [2:0] kind,
                                           logic cons);
        t_out_item r;
        r              = '0;
        r.write_enable = 1'b1;
        r.write_index  = idx;
        r.item_done    = 1'b1;
        r.item_kind    = kind;
        r.consumed     = cons;
        return r;
    endfunction

    always_comb begin
        eof        = i_item.end_of_input;
        c          = i_item.byte_in;
        line_end   = eof || (c == CH_NUL) || (c == CH_LF);
        back_idx   = (r_pos != '0) ? r_pos - 1'b1 : '0;
        n_phase    = r_phase;
        n_pos      = r_pos;
        o_result   = '0;
        o_result.consumed = 1'b1;
        do_store   = 1'b0;
        store_pos  = r_pos;
        store_byte = c;
        full_kind  = KIND_ERROR;

        // budget gone before reading: nothing is consumed
        if (r_phase != PH_ESC && r_pos >= i_buffer_size) begin
            o_result = f_finish(back_idx, (r_phase == PH_UNQ) ? KIND_ERROR : KIND_NOTHING,
                                1'b0);
            n_phase  = PH_IDLE;
            n_pos    = '0;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (!eof && (c == CH_SPACE || c == CH_TAB)) begin
                        // blank skipped
                    end else if (line_end || c == CH_SEMI) begin
                        o_result = f_finish('0, KIND_NOTHING, eof);
                        n_phase  = PH_IDLE;
                        n_pos    = '0;
                    end else if (c == CH_EQUAL) begin
                        o_result = f_finish('0, KIND_EQUAL, 1'b1);
                        n_phase  = PH_IDLE;
                        n_pos    = '0;
                    end else if (c == CH_QUOTE) begin
                        n_phase = PH_QUO;
                        n_pos   = '0;
                    end else begin
                        n_phase   = PH_UNQ;
                        store_pos = '0;
                        do_store  = 1'b1;
                    end
                end
                PH_UNQ: begin
                    if (line_end) begin
                        o_result = f_finish(r_pos, KIND_UNQUOTED, eof);
                        n_phase  = PH_IDLE;
                        n_pos    = '0;
                    end else if (c == CH_SPACE || c == CH_TAB || c == CH_EQUAL) begin
                        o_result = f_finish(r_pos, KIND_UNQUOTED, 1'b1);
                        n_phase  = PH_IDLE;
                        n_pos    = '0;
                    end else begin
                        do_store = 1'b1;
                    end
                end
                PH_QUO: begin
                    full_kind = KIND_NOTHING;
                    if (line_end) begin
                        o_result = f_finish(r_pos, KIND_ERROR, eof);
                        n_phase  = PH_IDLE;
                        n_pos    = '0;
                    end else if (c == CH_STAR) begin
                        n_phase = PH_ESC;
                    end else if (c == CH_QUOTE) begin
                        o_result = f_finish(r_pos, KIND_QUOTED, 1'b1);
                        n_phase  = PH_IDLE;
                        n_pos    = '0;
                    end else begin
                        do_store = 1'b1;
                    end
                end
                PH_ESC: begin
                    full_kind = KIND_NOTHING;
                    if (line_end) begin
                        o_result = f_finish(r_pos, KIND_ERROR, eof);
                        n_phase  = PH_IDLE;
                        n_pos    = '0;
                    end else begin
                        if (c == CH_LO_N || c == CH_UP_N) begin
                            store_byte = CH_LF;
                        end else if (c == CH_LO_E || c == CH_UP_E) begin
                            store_byte = CH_ESC;
                        end
                        n_phase  = PH_QUO;
                        do_store = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        if (do_store) begin
            // last place of the buffer takes the terminator instead
            if ({1'b0, store_pos} + 17'd1 >= {1'b0, i_buffer_size}) begin
                o_result = f_finish(store_pos, full_kind, 1'b1);
                n_phase  = PH_IDLE;
                n_pos    = '0;
            end else begin
                o_result.write_enable = 1'b1;
                o_result.write_index  = store_pos;
                o_result.write_byte   = store_byte;
                n_pos                 = store_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
        end
    end

endmodule

FILE: design/qwt_outbuf.sv
// result register with one skid entry behind it
// depends on qwt_pkg
`timescale 1ns / 1ps

module qwt_outbuf
    import qwt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_item,
    input  logic      i_stall,
    output logic      o_valid,
    output t_out_item o_item,
    output logic      o_full
);

    logic      r_out_valid;
    logic      r_skid_valid;
    t_out_item r_out_item;
    t_out_item r_skid_item;
    logic      pop;

    assign pop     = r_out_valid && !i_stall;
    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;
    assign o_full  = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // no push while the skid entry is held
            if (pop) begin
                r_out_item   <= r_skid_item;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out_item  <= i_item;
                r_out_valid <= 1'b1;
            end else begin
                r_skid_item  <= i_item;
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

FILE: design/quoted_word_tokenizer_top.sv
// top level of the quoted word tokenizer: config register, core, result buffer
// depends on qwt_pkg, qwt_core, qwt_outbuf and assert_macros.svh
`timescale 1ns / 1ps

// The tokenizer takes one character per item (or an end-of-input mark) and
// returns exactly one result item per input item: an optional byte written to
// the caller's item buffer, an item-done flag with its kind, and a consumed
// flag. When consumed is 0 the caller must present the same character again
// as the next item. It takes one item per cycle while o_in_stall is low: the
// phase and write position update, which every item depends on, is shallow
// compare-and-select logic, and a result register with one skid entry lets a
// new item in while a finished result waits. Each result is registered in the
// result register or, while it is held, the skid entry. o_in_stall rises only
// when both the result register and the skid entry are occupied. buffer_size
// is written through the configuration channel, which is always ready; it
// resets to 256 and should be changed only while no item is in flight.

`include "assert_macros.svh"

module quoted_word_tokenizer_top
    import qwt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input items
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_in_item,
    // result items
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_item,
    // configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [BufSizeW-1:0] i_cfg_data
);

    logic [BufSizeW-1:0] r_buffer_size;
    logic                accept;
    logic                buf_full;
    t_out_item           result;

    // input side stalls only when the skid entry is taken
    assign o_in_stall  = buf_full;
    assign accept      = i_in_valid && !buf_full;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= BUF_SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_buffer_size <= i_cfg_data;
        end
    end

    // phase / position state and the per-item step
    qwt_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (i_in_item),
        .i_buffer_size (r_buffer_size),
        .o_result      (result)
    );

    // result register plus skid entry
    qwt_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (result),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .o_full  (buf_full)
    );

    // a held skid entry always sits behind a valid result
    `QWT_ASSERT(a_skid_behind_out, i_clk, i_rst_n, !buf_full || o_out_valid)

    // every accepted item leaves a result to deliver
    `QWT_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, accept, o_out_valid)

    // a finished item always writes its terminator
    `QWT_ASSERT(a_done_writes, i_clk, i_rst_n, !(accept && result.item_done) || result.write_enable)

endmodule

FILE: tb/qwt_token_checker.sv
// result checker for the quoted word tokenizer: watches the item channels,
// predicts each result item and compares it; depends on qwt_pkg
`timescale 1ns / 1ps

module qwt_token_checker
    import qwt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  t_in_item            i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  t_out_item           i_out_item,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [BufSizeW-1:0] i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_BARE,
        SCAN_QUOTED,
        SCAN_ESCAPED
    } t_scan_phase;

    t_scan_phase         scan_phase;
    logic [BufSizeW-1:0] fill_pos;
    logic [BufSizeW-1:0] buf_limit;
    t_out_item           result_q[$];
    int                  shown;

    // terminator written, back to idle
    function automatic t_out_item close_item(input logic [BufSizeW-1:0] idx,
                                             input logic [2:0] kind, input logic cons);
        t_out_item r;
        r = '0;
        r.write_enable = 1'b1;
        r.write_index  = idx;
        r.item_done    = 1'b1;
        r.item_kind    = kind;
        r.consumed     = cons;
        scan_phase = SCAN_IDLE;
        fill_pos   = '0;
        return r;
    endfunction

    // last buffer place is reserved for the terminator
    function automatic t_out_item store_byte(input logic [7:0] v, input logic [2:0] full_kind);
        t_out_item r;
        if (32'(fill_pos) + 32'd1 >= 32'(buf_limit))
            return close_item(fill_pos, full_kind, 1'b1);
        r = '0;
        r.write_enable = 1'b1;
        r.write_index  = fill_pos;
        r.write_byte   = v;
        r.consumed     = 1'b1;
        fill_pos = fill_pos + 1'b1;
        return r;
    endfunction

    function automatic t_out_item tokenize_char(input t_in_item it);
        t_out_item  r;
        logic       eoi;
        logic [7:0] c;
        logic       line_end;
        logic [7:0] v;
        eoi      = it.end_of_input;
        c        = it.byte_in;
        line_end = eoi || c == CH_NUL || c == CH_LF;
        r = '0;
        r.consumed = 1'b1;
        // budget already used up: nothing read, terminator one place back
        if (scan_phase != SCAN_ESCAPED && fill_pos >= buf_limit)
            return close_item((fill_pos != 16'd0) ? fill_pos - 1'b1 : 16'd0,
                              (scan_phase == SCAN_BARE) ? KIND_ERROR : KIND_NOTHING, 1'b0);
        case (scan_phase)
            SCAN_IDLE: begin
                if (!eoi && (c == CH_SPACE || c == CH_TAB)) begin
                    // blank skipped, plain consume
                end else if (line_end || c == CH_SEMI) begin
                    r = close_item(16'd0, KIND_NOTHING, eoi);
                end else if (c == CH_EQUAL) begin
                    r = close_item(16'd0, KIND_EQUAL, 1'b1);
                end else if (c == CH_QUOTE) begin
                    scan_phase = SCAN_QUOTED;
                    fill_pos   = '0;
                end else begin
                    fill_pos   = '0;
                    scan_phase = SCAN_BARE;
                    r = store_byte(c, KIND_ERROR);
                end
            end
            SCAN_BARE: begin
                if (line_end)
                    r = close_item(fill_pos, KIND_UNQUOTED, eoi);
                else if (c == CH_SPACE || c == CH_TAB || c == CH_EQUAL)
                    r = close_item(fill_pos, KIND_UNQUOTED, 1'b1);
                else
                    r = store_byte(c, KIND_ERROR);
            end
            SCAN_QUOTED: begin
                if (line_end)
                    r = close_item(fill_pos, KIND_ERROR, eoi);
                else if (c == CH_STAR)
                    scan_phase = SCAN_ESCAPED;
                else if (c == CH_QUOTE)
                    r = close_item(fill_pos, KIND_QUOTED, 1'b1);
                else
                    r = store_byte(c, KIND_NOTHING);
            end
            default: begin
                if (line_end) begin
                    r = close_item(fill_pos, KIND_ERROR, eoi);
                end else begin
                    v = c;
                    if (c == CH_LO_N || c == CH_UP_N)
                        v = CH_LF;
                    else if (c == CH_LO_E || c == CH_UP_E)
                        v = CH_ESC;
                    scan_phase = SCAN_QUOTED;
                    r = store_byte(v, KIND_NOTHING);
                end
            end
        endcase
        return r;
    endfunction

    function automatic string show_result(input t_out_item r);
        return $sformatf("we=%0d idx=%0d byte=%02h done=%0d kind=%0d cons=%0d",
                         r.write_enable, r.write_index, r.write_byte,
                         r.item_done, r.item_kind, r.consumed);
    endfunction

    task automatic note_failure(input string what);
        o_fail_count = o_fail_count + 1;
        if (shown < 10) begin
            shown = shown + 1;
            $display("[%0t] tokenizer mismatch: %s", $realtime, what);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            scan_phase = SCAN_IDLE;
            fill_pos   = '0;
            buf_limit  = BUF_SIZE_RESET;
            result_q.delete();
            o_fail_count = 0;
            shown = 0;
        end else begin
            // older results first, an item's own result cannot share its edge
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    note_failure({"unexpected result ", show_result(i_out_item)});
                end else begin
                    want = result_q.pop_front();
                    if (want.write_enable !== i_out_item.write_enable ||
                        want.write_index  !== i_out_item.write_index  ||
                        want.write_byte   !== i_out_item.write_byte   ||
                        want.item_done    !== i_out_item.item_done    ||
                        want.item_kind    !== i_out_item.item_kind    ||
                        want.consumed     !== i_out_item.consumed)
                        note_failure({"expected ", show_result(want),
                                      " got ", show_result(i_out_item)});
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                buf_limit = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                result_q.push_back(tokenize_char(i_in_item));
        end
        o_pending = result_q.size();
    end

endmodule

FILE: tb/tb.sv
// top of the quoted word tokenizer testbench: clock, reset, stimulus, verdict
// depends on qwt_pkg, quoted_word_tokenizer_top and qwt_token_checker
`timescale 1ns / 1ps

module tb;
    import qwt_pkg::*;

    // cycles with no handshake at all before the run is declared hung;
    // the longest correct quiet stretch is a long input gap overlapping a
    // long output stall
    localparam int StuckLimit    = 2000;
    localparam int PhaseCount    = 8;
    localparam int ItemsPerPhase = 75;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_in_item            i_in_item;
    logic                o_out_valid;
    logic                i_out_stall;
    t_out_item           o_out_item;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [BufSizeW-1:0] i_cfg_data;

    int       mismatch_total;
    int       pending_results;
    int       stuck_cycles;
    logic     quiet_mode;      // no gaps on either side while set
    t_in_item char_backlog[$]; // characters of tokens not yet sent

    quoted_word_tokenizer_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // the checker sees exactly what crosses each channel
    qwt_token_checker token_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (mismatch_total),
        .o_pending    (pending_results)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hang detection: count edges where nothing moved on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        while (stuck_cycles < StuckLimit)
            @(posedge i_clk);
        $display("** quoted_word_tokenizer_top: FAILED **");
        $finish;
    end

    // mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_mode || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure: a run of open cycles, then maybe a stall
    initial begin
        int open_run;
        int stall_run;
        i_out_stall = 1'b0;
        forever begin
            open_run  = $urandom_range(1, 12);
            stall_run = pick_gap();
            i_out_stall <= 1'b0;
            repeat (open_run) @(negedge i_clk);
            if (stall_run > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_run) @(negedge i_clk);
            end
        end
    end

    function automatic t_in_item make_char(input logic [7:0] c, input logic eoi);
        t_in_item it;
        it.byte_in      = c;
        it.end_of_input = eoi;
        return it;
    endfunction

    // send one item: called and returning at a falling edge; valid stays
    // high across back-to-back items so it is never lowered and raised in one step
    task automatic push_char(input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do
            @(posedge i_clk);
        while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic feed(input logic [7:0] c);
        push_char(make_char(c, 1'b0));
    endtask

    task automatic feed_eof();
        push_char(make_char(8'($urandom()), 1'b1));
    endtask

    // stop sending and let every predicted result come back
    task automatic settle_results();
        i_in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // config writes only happen with nothing in flight
    task automatic set_buffer_size(input logic [BufSizeW-1:0] size);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // word content: printable, sometimes high bytes; never quote, star or '='
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
                                            : 8'($urandom_range(33, 126));
        while (b == CH_QUOTE || b == CH_STAR || b == CH_EQUAL);
        return b;
    endfunction

    // append one token to the backlog; mostly well-formed words, with
    // separators, premature line ends and raw noise mixed in
    task automatic queue_token();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            // unquoted word and the separator that ends it
            len = $urandom_range(1, 10);
            repeat (len) char_backlog.push_back(make_char(plain_byte(), 1'b0));
            case ($urandom_range(0, 5))
                0: char_backlog.push_back(make_char(CH_SPACE, 1'b0));
                1: char_backlog.push_back(make_char(CH_TAB, 1'b0));
                2: char_backlog.push_back(make_char(CH_EQUAL, 1'b0));
                3: char_backlog.push_back(make_char(CH_LF, 1'b0));
                4: char_backlog.push_back(make_char(CH_NUL, 1'b0));
                default: char_backlog.push_back(make_char(8'($urandom()), 1'b1));
            endcase
        end else if (pick < 55) begin
            // quoted word with escapes, usually closed properly
            char_backlog.push_back(make_char(CH_QUOTE, 1'b0));
            len = $urandom_range(0, 10);
            repeat (len) begin
                if ($urandom_range(0, 3) == 0) begin
                    char_backlog.push_back(make_char(CH_STAR, 1'b0));
                    case ($urandom_range(0, 6))
                        0: char_backlog.push_back(make_char(CH_STAR, 1'b0));
                        1: char_backlog.push_back(make_char(CH_QUOTE, 1'b0));
                        2: char_backlog.push_back(make_char(CH_LO_N, 1'b0));
                        3: char_backlog.push_back(make_char(CH_UP_N, 1'b0));
                        4: char_backlog.push_back(make_char(CH_LO_E, 1'b0));
                        5: char_backlog.push_back(make_char(CH_UP_E, 1'b0));
                        default: char_backlog.push_back(make_char(plain_byte(), 1'b0));
                    endcase
                end else begin
                    char_backlog.push_back(make_char(plain_byte(), 1'b0));
                end
            end
            case ($urandom_range(0, 9))
                0: char_backlog.push_back(make_char(CH_LF, 1'b0));
                1: char_backlog.push_back(make_char(CH_NUL, 1'b0));
                2: char_backlog.push_back(make_char(8'($urandom()), 1'b1));
                3: begin
                    // line end right after the escape star
                    char_backlog.push_back(make_char(CH_STAR, 1'b0));
                    char_backlog.push_back(make_char(CH_LF, 1'b0));
                end
                default: char_backlog.push_back(make_char(CH_QUOTE, 1'b0));
            endcase
        end else if (pick < 65) begin
            char_backlog.push_back(make_char(CH_EQUAL, 1'b0));
        end else if (pick < 72) begin
            char_backlog.push_back(make_char(CH_SEMI, 1'b0));
        end else if (pick < 80) begin
            repeat ($urandom_range(1, 3))
                char_backlog.push_back(make_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB,
                                                 1'b0));
        end else if (pick < 86) begin
            char_backlog.push_back(make_char(CH_LF, 1'b0));
        end else if (pick < 89) begin
            char_backlog.push_back(make_char(CH_NUL, 1'b0));
        end else if (pick < 93) begin
            char_backlog.push_back(make_char(8'($urandom()), 1'b1));
        end else begin
            // raw noise: any byte, now and then with end of input
            repeat ($urandom_range(1, 4))
                char_backlog.push_back(make_char(8'($urandom()), $urandom_range(0, 7) == 0));
        end
    endtask

    initial begin
        logic [BufSizeW-1:0] size;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        quiet_mode  = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part at the reset buffer size: blanks, separators,
        // equal, every escape form, high byte, terminators
        feed(CH_SPACE);
        feed(CH_TAB);
        feed(CH_SEMI);         // nothing, pushed back
        feed(CH_EQUAL);        // equal item
        feed("a");
        feed(CH_EQUAL);        // ends the unquoted item, consumed
        feed(CH_QUOTE);
        feed(CH_STAR);
        feed(CH_LO_N);         // becomes newline
        feed(CH_STAR);
        feed(CH_UP_E);         // becomes escape code
        feed(CH_STAR);
        feed(CH_QUOTE);        // escaped quote stored
        feed(CH_STAR);
        feed(CH_STAR);         // double star stored as one
        feed(CH_STAR);
        feed("x");             // any other escaped char kept as is
        feed(CH_QUOTE);        // quoted item closes
        feed(8'hff);
        feed(CH_NUL);          // unquoted item ends, pushed back
        feed(CH_LF);           // nothing in idle
        feed_eof();            // end of input in idle
        feed(CH_QUOTE);
        feed(CH_STAR);
        feed_eof();            // premature end right after the star

        // a buffer of one place: every stored byte hits the full buffer
        settle_results();
        set_buffer_size(16'd1);
        feed("a");
        feed(CH_QUOTE);
        feed("b");

        // shrink the buffer in the middle of an unquoted item
        settle_results();
        set_buffer_size(BUF_SIZE_RESET);
        feed("c");
        feed("d");
        feed("e");
        settle_results();
        set_buffer_size(16'd2);
        feed("f");             // budget gone before reading: not consumed

        // random phases; a phase may stop mid token, so a smaller size
        // written next can land under the current write position
        for (int ph = 0; ph < PhaseCount; ph++) begin
            case (ph)
                0: size = 16'd3;
                1: size = 16'd1;
                2: size = 16'hffff;
                3: size = 16'($urandom_range(2, 12));
                4: size = 16'($urandom_range(1, 65535));
                5: size = 16'd2;
                6: size = 16'($urandom_range(4, 40));
                default: size = BUF_SIZE_RESET;
            endcase
            settle_results();
            quiet_mode = (ph % 3 == 2);
            set_buffer_size(size);
            repeat (ItemsPerPhase) begin
                if (char_backlog.size() == 0)
                    queue_token();
                push_char(char_backlog.pop_front());
            end
        end

        // all stimulus in: wait for the last results, then a short tail
        // in which any stray result would still be caught
        settle_results();
        repeat (10) @(negedge i_clk);
        if (mismatch_total == 0)
            $display("** quoted_word_tokenizer_top: PASSED **");
        else
            $display("** quoted_word_tokenizer_top: FAILED **");
        $finish;
    end

endmodule
